FILE: rtl/value_table_sort_search_core_defines.svh
// Assertion macros shared by the value table sort and search block.
`ifndef VALUE_TABLE_SORT_SEARCH_CORE_DEFINES_SVH
`define VALUE_TABLE_SORT_SEARCH_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VTSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VTSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VTSS_ASSERT_IMP(label, ante, cons, msg)
`define VTSS_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/vtss_pkg.sv
// Types, codes and sizes shared by the value table sort and search block.
`default_nettype none

package vtss_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] MODE_APPEND    = 3'd0;
  localparam logic [2:0] MODE_SORT_ASC  = 3'd1;
  localparam logic [2:0] MODE_SORT_DESC = 3'd2;
  localparam logic [2:0] MODE_READ      = 3'd3;
  localparam logic [2:0] MODE_SEARCH    = 3'd4;

  localparam logic [2:0] KIND_APPENDED = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_SORTED   = 3'd2;
  localparam logic [2:0] KIND_ELEMENT  = 3'd3;
  localparam logic [2:0] KIND_EMPTY    = 3'd4;
  localparam logic [2:0] KIND_MATCH    = 3'd5;
  localparam logic [2:0] KIND_SDONE    = 3'd6;
  localparam logic [2:0] KIND_INVALID  = 3'd7;

  localparam logic [1:0] J_HOLD = 2'd0;
  localparam logic [1:0] J_ZERO = 2'd1;
  localparam logic [1:0] J_INC  = 2'd2;
  localparam logic [1:0] J_IP1  = 2'd3;

  localparam logic RA_JNEXT = 1'b0;
  localparam logic RA_I     = 1'b1;

  localparam logic [1:0] WR_NONE   = 2'd0;
  localparam logic [1:0] WR_APPEND = 2'd1;
  localparam logic [1:0] WR_SWAP   = 2'd2;
  localparam logic [1:0] WR_I      = 2'd3;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic [4:0]               index;
    logic signed [DATA_W-1:0] element;
    logic [5:0]               match_count;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic       take_in;
    logic       rd_en;
    logic       rd_sel;
    logic [1:0] j_op;
    logic       i_inc;
    logic [1:0] wr_op;
    logic       cur_load;
    logic       cnt_inc;
    logic       mcnt_inc;
    logic       emit;
    logic [2:0] kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       cnt_zero;
    logic       cnt_le1;
    logic       full;
    logic       j_last;
    logic       i_last;
    logic       swap;
    logic       match;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/vtss_datapath.sv
// Datapath: table memory, counters, compare logic and the result register.
`default_nettype none

module vtss_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vtss_pkg::req_t    req,
  input  wire vtss_pkg::cmd_t    cmd,
  output vtss_pkg::status_t      st,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output vtss_pkg::res_t         res
);

  logic [vtss_pkg::DATA_W-1:0] mem [vtss_pkg::DEPTH];

  logic [2:0]                         mode;
  logic signed [vtss_pkg::DATA_W-1:0] key;
  logic [vtss_pkg::CNT_W-1:0]         cnt;
  logic [vtss_pkg::CNT_W-1:0]         mcnt;
  logic [vtss_pkg::IDX_W-1:0]         i;
  logic [vtss_pkg::IDX_W-1:0]         j;
  logic [vtss_pkg::IDX_W-1:0]         j_next;
  logic signed [vtss_pkg::DATA_W-1:0] cur;
  logic signed [vtss_pkg::DATA_W-1:0] rd_data;
  logic [vtss_pkg::IDX_W-1:0]         rd_addr;
  logic [vtss_pkg::IDX_W-1:0]         wr_addr;
  logic [vtss_pkg::DATA_W-1:0]        wr_data;
  logic                               wr_en;
  vtss_pkg::res_t                     res_next;

  always_comb begin
    case (cmd.j_op)
      vtss_pkg::J_ZERO: j_next = '0;
      vtss_pkg::J_INC:  j_next = j + vtss_pkg::IDX_W'(1);
      vtss_pkg::J_IP1:  j_next = i + vtss_pkg::IDX_W'(1);
      default:          j_next = j;
    endcase
  end

  assign rd_addr = (cmd.rd_sel == vtss_pkg::RA_I) ? i : j_next;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = j;
    wr_data = cur;
    case (cmd.wr_op)
      vtss_pkg::WR_APPEND: begin
        wr_addr = cnt[vtss_pkg::IDX_W-1:0];
        wr_data = key;
      end
      vtss_pkg::WR_SWAP: wr_addr = j;
      vtss_pkg::WR_I:    wr_addr = i;
      default:           wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      mode <= req.mode;
      key  <= req.value;
      i    <= '0;
      j    <= '0;
      mcnt <= '0;
    end else begin
      j <= j_next;
      if (cmd.i_inc) begin
        i <= i + vtss_pkg::IDX_W'(1);
      end
      if (cmd.mcnt_inc) begin
        mcnt <= mcnt + vtss_pkg::CNT_W'(1);
      end
    end
    if (cmd.cur_load) begin
      cur <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + vtss_pkg::CNT_W'(1);
    end
  end

  assign st.mode     = mode;
  assign st.cnt_zero = (cnt == '0);
  assign st.cnt_le1  = (cnt <= vtss_pkg::CNT_W'(1));
  assign st.full     = (cnt >= vtss_pkg::CNT_W'(vtss_pkg::DEPTH));
  assign st.j_last   = (vtss_pkg::CNT_W'(j) + vtss_pkg::CNT_W'(1) == cnt);
  assign st.i_last   = (vtss_pkg::CNT_W'(i) + vtss_pkg::CNT_W'(2) == cnt);
  assign st.swap     = (mode == vtss_pkg::MODE_SORT_DESC) ? (rd_data > cur) : (cur > rd_data);
  assign st.match    = (rd_data == key);
  assign st.out_free = !res_valid || res_ready;

  always_comb begin
    res_next             = '0;
    res_next.kind        = cmd.kind;
    res_next.last        = 1'b1;
    case (cmd.kind)
      vtss_pkg::KIND_APPENDED: res_next.index = 5'(cnt);
      vtss_pkg::KIND_ELEMENT: begin
        res_next.index   = 5'(j);
        res_next.element = rd_data;
        res_next.last    = st.j_last;
      end
      vtss_pkg::KIND_MATCH: begin
        res_next.index   = 5'(j);
        res_next.element = rd_data;
        res_next.last    = 1'b0;
      end
      vtss_pkg::KIND_SDONE: res_next.match_count = 6'(mcnt);
      default: res_next.index = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vtss_ctrl.sv
// Controller state machine that sequences append, sort, read out and search.
`default_nettype none

module vtss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire vtss_pkg::status_t st,
  output vtss_pkg::cmd_t         cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_READ      = 4'd2;
  localparam logic [3:0] S_SEARCH    = 4'd3;
  localparam logic [3:0] S_SDONE     = 4'd4;
  localparam logic [3:0] S_SORT_I    = 4'd5;
  localparam logic [3:0] S_SORT_CUR  = 4'd6;
  localparam logic [3:0] S_SORT_J    = 4'd7;
  localparam logic [3:0] S_SORT_WI   = 4'd8;
  localparam logic [3:0] S_SORT_DONE = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.j_op     = vtss_pkg::J_HOLD;
    cmd.rd_sel   = vtss_pkg::RA_JNEXT;
    cmd.wr_op    = vtss_pkg::WR_NONE;
    cmd.kind     = vtss_pkg::KIND_INVALID;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.take_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.mode) inside
          vtss_pkg::MODE_APPEND: begin
            if (st.out_free) begin
              cmd.emit = 1'b1;
              if (st.full) begin
                cmd.kind = vtss_pkg::KIND_FULL;
              end else begin
                cmd.kind    = vtss_pkg::KIND_APPENDED;
                cmd.wr_op   = vtss_pkg::WR_APPEND;
                cmd.cnt_inc = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          vtss_pkg::MODE_SORT_ASC, vtss_pkg::MODE_SORT_DESC: begin
            state_next = st.cnt_le1 ? S_SORT_DONE : S_SORT_I;
          end
          vtss_pkg::MODE_READ: begin
            if (st.cnt_zero) begin
              if (st.out_free) begin
                cmd.emit   = 1'b1;
                cmd.kind   = vtss_pkg::KIND_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_READ;
            end
          end
          vtss_pkg::MODE_SEARCH: begin
            if (st.cnt_zero) begin
              state_next = S_SDONE;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_SEARCH;
            end
          end
          default: begin
            if (st.out_free) begin
              cmd.emit   = 1'b1;
              cmd.kind   = vtss_pkg::KIND_INVALID;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = vtss_pkg::KIND_ELEMENT;
          if (st.j_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.j_op  = vtss_pkg::J_INC;
            cmd.rd_en = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        if (!st.match || st.out_free) begin
          if (st.match) begin
            cmd.emit     = 1'b1;
            cmd.kind     = vtss_pkg::KIND_MATCH;
            cmd.mcnt_inc = 1'b1;
          end
          if (st.j_last) begin
            state_next = S_SDONE;
          end else begin
            cmd.j_op  = vtss_pkg::J_INC;
            cmd.rd_en = 1'b1;
          end
        end
      end
      S_SDONE: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = vtss_pkg::KIND_SDONE;
          state_next = S_IDLE;
        end
      end
      S_SORT_I: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = vtss_pkg::RA_I;
        cmd.j_op   = vtss_pkg::J_IP1;
        state_next = S_SORT_CUR;
      end
      S_SORT_CUR: begin
        cmd.cur_load = 1'b1;
        cmd.rd_en    = 1'b1;
        state_next   = S_SORT_J;
      end
      S_SORT_J: begin
        if (st.swap) begin
          cmd.wr_op    = vtss_pkg::WR_SWAP;
          cmd.cur_load = 1'b1;
        end
        if (st.j_last) begin
          state_next = S_SORT_WI;
        end else begin
          cmd.j_op  = vtss_pkg::J_INC;
          cmd.rd_en = 1'b1;
        end
      end
      S_SORT_WI: begin
        cmd.wr_op = vtss_pkg::WR_I;
        if (st.i_last) begin
          state_next = S_SORT_DONE;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_SORT_I;
        end
      end
      S_SORT_DONE: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = vtss_pkg::KIND_SORTED;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/value_table_sort_search_core.sv
// Top level of the value table: one request in, its results out in order.
// Append and invalid requests give their result from the decode state once the result register is free.
// Sort does one memory read per compare.
// One request is in work at a time; a new request is taken once the last result is queued.
// Synchronous reset empties the table and drops any pending result.
`default_nettype none

`include "value_table_sort_search_core_defines.svh"

module value_table_sort_search_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire vtss_pkg::req_t req,
  output logic                res_valid,
  input  wire logic           res_ready,
  output vtss_pkg::res_t      res
);

  vtss_pkg::cmd_t    cmd;
  vtss_pkg::status_t st;

  vtss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  vtss_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  `VTSS_ASSERT_IMP(a_emit_free, cmd.emit, st.out_free, "result overwritten while pending")
  `VTSS_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")
  `VTSS_ASSERT_IMP(a_match_not_last, res_valid && res.kind == vtss_pkg::KIND_MATCH, !res.last, "match marked last")

endmodule

`default_nettype wire
